[rtl/gsa_pkg.sv]
package gsa_pkg;

    localparam int MAX_LEN_DEF = 32;
    localparam int SCORE_W     = 10;
    localparam int ROW_W       = 6;
    localparam int SIM_W       = 5;

    // item kinds
    localparam logic [1:0] K_LOAD_A = 2'd0;
    localparam logic [1:0] K_LOAD_B = 2'd1;
    localparam logic [1:0] K_RUN    = 2'd2;

    // traceback codes
    localparam logic [1:0] TR_DIAG = 2'd0;
    localparam logic [1:0] TR_LEFT = 2'd1;
    localparam logic [1:0] TR_UP   = 2'd2;

    localparam logic [7:0] CH_A   = 8'h41;
    localparam logic [7:0] CH_C   = 8'h43;
    localparam logic [7:0] CH_G   = 8'h47;
    localparam logic [7:0] CH_T   = 8'h54;
    localparam logic [7:0] CH_GAP = 8'h2d;

    localparam logic signed [SIM_W-1:0] SIM [5][5] = '{
        '{5'sd10, -5'sd1, -5'sd3, -5'sd4, -5'sd5},
        '{-5'sd1, 5'sd7,  -5'sd5, -5'sd3, -5'sd5},
        '{-5'sd3, -5'sd5, 5'sd9,  5'sd0,  -5'sd5},
        '{-5'sd4, -5'sd3, 5'sd0,  5'sd8,  -5'sd5},
        '{-5'sd5, -5'sd5, -5'sd5, -5'sd5, 5'sd0}
    };

    typedef logic signed [SCORE_W-1:0] t_score;

    // one beat handed from cell to cell along the chain
    typedef struct packed {
        logic             v;
        logic [ROW_W-1:0] row;
        logic [7:0]       a;
        t_score           h;
    } t_link;

    function automatic logic [2:0] base_idx(input logic [7:0] ch);
        logic [2:0] r;
        case (ch)
            CH_A:    r = 3'd0;
            CH_C:    r = 3'd1;
            CH_G:    r = 3'd2;
            CH_T:    r = 3'd3;
            default: r = 3'd4;
        endcase
        return r;
    endfunction

    function automatic logic signed [SIM_W-1:0] sim(input logic [7:0] x, input logic [7:0] y);
        return SIM[base_idx(x)][base_idx(y)];
    endfunction

endpackage

[rtl/gsa_ram.sv]
module gsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[rtl/gsa_cell.sv]
module gsa_cell #(
    parameter int MAX_LEN = gsa_pkg::MAX_LEN_DEF,
    parameter int IDX     = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_init,
    input  gsa_pkg::t_link        i_link,
    output gsa_pkg::t_link        o_link,
    input  logic                  i_b_we,
    input  logic [7:0]            i_b_sym,
    output logic [7:0]            o_b,
    input  logic [(MAX_LEN > 1 ? $clog2(MAX_LEN) : 1)-1:0] i_tr_raddr,
    output logic [1:0]            o_tr_q
);

    localparam int AW = MAX_LEN > 1 ? $clog2(MAX_LEN) : 1;
    localparam int SW = gsa_pkg::SCORE_W;
    localparam gsa_pkg::t_score UP0 = SW'(-5 * IDX);
    localparam gsa_pkg::t_score LP0 = SW'(-5 * (IDX - 1));

    logic                          r_v;
    logic [gsa_pkg::ROW_W-1:0]     r_row;
    logic [7:0]                    r_a;
    logic [7:0]                    r_b;
    gsa_pkg::t_score               r_h;
    gsa_pkg::t_score               r_lp;

    logic signed [SW:0]            w_d;
    logic signed [SW:0]            w_l;
    logic signed [SW:0]            w_u;
    logic signed [SW:0]            w_best;
    logic [1:0]                    w_tr;
    logic [gsa_pkg::ROW_W-1:0]     w_rowm1;

    // score this cell from diagonal, left and up neighbors
    always_comb begin
        w_d = (SW+1)'(r_lp) + (SW+1)'(gsa_pkg::sim(i_link.a, r_b));
        w_l = (SW+1)'(i_link.h) + (SW+1)'(gsa_pkg::sim(gsa_pkg::CH_GAP, r_b));
        w_u = (SW+1)'(r_h) + (SW+1)'(gsa_pkg::sim(i_link.a, gsa_pkg::CH_GAP));
        w_best = w_d;
        if (w_l > w_best) begin
            w_best = w_l;
        end
        if (w_u > w_best) begin
            w_best = w_u;
        end
        if (w_best == w_l) begin
            w_tr = gsa_pkg::TR_LEFT;
        end else if (w_best == w_u) begin
            w_tr = gsa_pkg::TR_UP;
        end else begin
            w_tr = gsa_pkg::TR_DIAG;
        end
        w_rowm1 = i_link.row - gsa_pkg::ROW_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= i_link.v;
        end
    end

    // hold the column score, pass the row on
    always_ff @(posedge i_clk) begin
        if (i_init) begin
            r_h  <= UP0;
            r_lp <= LP0;
        end else if (i_link.v) begin
            r_h  <= w_best[SW-1:0];
            r_lp <= i_link.h;
        end
        r_a   <= i_link.a;
        r_row <= i_link.row;
        if (i_b_we) begin
            r_b <= i_b_sym;
        end
    end

    assign o_link = '{v: r_v, row: r_row, a: r_a, h: r_h};
    assign o_b    = r_b;

    gsa_ram #(.WIDTH(2), .DEPTH(MAX_LEN)) u_trace (
        .i_clk   (i_clk),
        .i_we    (i_link.v),
        .i_waddr (w_rowm1[AW-1:0]),
        .i_wdata (w_tr),
        .i_raddr (i_tr_raddr),
        .o_rdata (o_tr_q)
    );

endmodule

[rtl/global_sequence_aligner_core.sv]
// Loads: one beat per cycle while the core is idle, no result.
// Run: fill streams the rows of A through the cell chain, skipped when one side is empty,
// then traceback walks the path back step by step (registered trace memory read in each cell),
// then emission reads the registered path memory per step; an empty run emits one empty beat.
// Input is stalled from the run beat until the last result is loaded into the output register.
// Reset (synchronous, active low) clears both sequence lengths and the control state.
module global_sequence_aligner_core #(
    parameter int MAX_LEN = gsa_pkg::MAX_LEN_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [1:0]                        i_kind,
    input  logic [7:0]                        i_symbol,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [7:0]                        o_aligned_a,
    output logic [7:0]                        o_aligned_b,
    output logic signed [gsa_pkg::SCORE_W-1:0] o_total_score,
    output logic                              o_last,
    output logic                              o_empty_res
);

    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int AW = MAX_LEN > 1 ? $clog2(MAX_LEN) : 1;
    localparam int PD = 2 * MAX_LEN;
    localparam int PW = $clog2(PD);
    localparam int CW = $clog2(PD + 1);
    localparam int SW = gsa_pkg::SCORE_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FEED  = 3'd1;
    localparam logic [2:0] ST_WAIT  = 3'd2;
    localparam logic [2:0] ST_TB_RD = 3'd3;
    localparam logic [2:0] ST_TB_US = 3'd4;
    localparam logic [2:0] ST_EM_RD = 3'd5;
    localparam logic [2:0] ST_EM_WR = 3'd6;
    localparam logic [2:0] ST_EMPTY = 3'd7;

    logic [2:0]      r_state;
    logic [LW-1:0]   r_len_a;
    logic [LW-1:0]   r_len_b;
    logic [LW-1:0]   r_feed;
    logic            r_rd_v;
    logic [LW-1:0]   r_rd_row;
    logic [LW-1:0]   r_ti;
    logic [LW-1:0]   r_tj;
    logic [CW-1:0]   r_cnt;
    logic [CW-1:0]   r_k;
    gsa_pkg::t_score r_total;

    logic            r_ov;
    logic [7:0]      r_oa;
    logic [7:0]      r_ob;
    gsa_pkg::t_score r_os;
    logic            r_olast;
    logic            r_oempty;

    logic            w_acc;
    logic            w_slot;
    logic            w_init;
    logic            w_a_we;
    logic [AW-1:0]   w_a_raddr;
    logic [7:0]      w_a_q;
    logic [LW-1:0]   w_tim1;
    logic [LW-1:0]   w_tjm1;
    logic            w_p_we;
    logic [15:0]     w_p_wdata;
    logic [CW-1:0]   w_p_ridx;
    logic [15:0]     w_p_q;
    logic [1:0]      w_tr;
    logic [7:0]      w_tb_b;
    logic [LW:0]     w_nm;
    gsa_pkg::t_link  w_sel;
    gsa_pkg::t_score w_h0;
    logic [LW+2:0]   w_row5;

    gsa_pkg::t_link  w_link [MAX_LEN + 1];
    logic [7:0]      w_b    [MAX_LEN];
    logic [1:0]      w_trq  [MAX_LEN];

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_acc      = i_in_valid && !o_in_stall;
    assign w_slot     = !r_ov || !i_out_stall;
    assign w_init     = w_acc && (i_kind == gsa_pkg::K_RUN);
    assign w_a_we     = w_acc && (i_kind == gsa_pkg::K_LOAD_A) && (r_len_a < LW'(MAX_LEN));
    assign w_tim1     = r_ti - LW'(1);
    assign w_tjm1     = r_tj - LW'(1);
    assign w_a_raddr  = (r_state == ST_FEED) ? r_feed[AW-1:0] : w_tim1[AW-1:0];
    assign w_nm       = (LW+1)'(r_len_a) + (LW+1)'(r_len_b);
    assign w_sel      = w_link[r_len_b];
    assign w_p_ridx   = r_cnt - CW'(1) - r_k;

    // border score -5 * row enters the first cell
    assign w_row5 = ((LW+3)'(r_rd_row) << 2) + (LW+3)'(r_rd_row);
    assign w_h0   = SW'(-$signed({1'b0, w_row5}));
    assign w_link[0] = '{v: r_rd_v, row: gsa_pkg::ROW_W'(r_rd_row), a: w_a_q, h: w_h0};

    gsa_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_seq_a (
        .i_clk   (i_clk),
        .i_we    (w_a_we),
        .i_waddr (r_len_a[AW-1:0]),
        .i_wdata (i_symbol),
        .i_raddr (w_a_raddr),
        .o_rdata (w_a_q)
    );

    // one cell per character of B
    for (genvar j = 1; j <= MAX_LEN; j++) begin : g_cell
        gsa_cell #(.MAX_LEN(MAX_LEN), .IDX(j)) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_init     (w_init),
            .i_link     (w_link[j-1]),
            .o_link     (w_link[j]),
            .i_b_we     (w_acc && (i_kind == gsa_pkg::K_LOAD_B) && (r_len_b == LW'(j - 1))),
            .i_b_sym    (i_symbol),
            .o_b        (w_b[j-1]),
            .i_tr_raddr (w_tim1[AW-1:0]),
            .o_tr_q     (w_trq[j-1])
        );
    end

    // pick the traceback step and the column it emits
    always_comb begin
        w_tb_b = w_b[w_tjm1[AW-1:0]];
        if (r_ti == '0) begin
            w_tr = gsa_pkg::TR_LEFT;
        end else if (r_tj == '0) begin
            w_tr = gsa_pkg::TR_UP;
        end else begin
            w_tr = w_trq[w_tjm1[AW-1:0]];
        end
        case (w_tr)
            gsa_pkg::TR_DIAG: w_p_wdata = {w_a_q, w_tb_b};
            gsa_pkg::TR_UP:   w_p_wdata = {w_a_q, gsa_pkg::CH_GAP};
            default:          w_p_wdata = {gsa_pkg::CH_GAP, w_tb_b};
        endcase
        w_p_we = (r_state == ST_TB_US);
    end

    gsa_ram #(.WIDTH(16), .DEPTH(PD)) u_path (
        .i_clk   (i_clk),
        .i_we    (w_p_we),
        .i_waddr (r_cnt[PW-1:0]),
        .i_wdata (w_p_wdata),
        .i_raddr (w_p_ridx[PW-1:0]),
        .o_rdata (w_p_q)
    );

    // sequencer: load, fill, traceback, emit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_len_a <= '0;
            r_len_b <= '0;
            r_rd_v  <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    r_rd_v <= 1'b0;
                    if (w_a_we) begin
                        r_len_a <= r_len_a + LW'(1);
                    end
                    if (w_acc && (i_kind == gsa_pkg::K_LOAD_B) && (r_len_b < LW'(MAX_LEN))) begin
                        r_len_b <= r_len_b + LW'(1);
                    end
                    if (w_init) begin
                        r_feed <= '0;
                        r_ti   <= r_len_a;
                        r_tj   <= r_len_b;
                        r_cnt  <= '0;
                        r_k    <= '0;
                        if (r_len_a == '0 && r_len_b == '0) begin
                            r_state <= ST_EMPTY;
                        end else if (r_len_a == '0 || r_len_b == '0) begin
                            r_total <= SW'(-5 * $signed({1'b0, w_nm}));
                            r_state <= ST_TB_RD;
                        end else begin
                            r_state <= ST_FEED;
                        end
                    end
                end
                ST_FEED: begin
                    if (r_feed < r_len_a) begin
                        r_rd_v   <= 1'b1;
                        r_rd_row <= r_feed + LW'(1);
                        r_feed   <= r_feed + LW'(1);
                    end else begin
                        r_rd_v  <= 1'b0;
                        r_state <= ST_WAIT;
                    end
                end
                ST_WAIT: begin
                    if (w_sel.v && w_sel.row == gsa_pkg::ROW_W'(r_len_a)) begin
                        r_total <= w_sel.h;
                        r_state <= ST_TB_RD;
                    end
                end
                ST_TB_RD: begin
                    if (r_ti == '0 && r_tj == '0) begin
                        r_state <= ST_EM_RD;
                    end else begin
                        r_state <= ST_TB_US;
                    end
                end
                ST_TB_US: begin
                    r_cnt <= r_cnt + CW'(1);
                    case (w_tr)
                        gsa_pkg::TR_DIAG: begin
                            r_ti <= w_tim1;
                            r_tj <= w_tjm1;
                        end
                        gsa_pkg::TR_UP: r_ti <= w_tim1;
                        default:        r_tj <= w_tjm1;
                    endcase
                    r_state <= ST_TB_RD;
                end
                ST_EM_RD: r_state <= ST_EM_WR;
                ST_EM_WR: begin
                    if (w_slot) begin
                        r_k <= r_k + CW'(1);
                        if (r_k + CW'(1) == r_cnt) begin
                            r_len_a <= '0;
                            r_len_b <= '0;
                            r_state <= ST_IDLE;
                        end else begin
                            r_state <= ST_EM_RD;
                        end
                    end
                end
                ST_EMPTY: begin
                    if (w_slot) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // output register: load a beat when the slot frees
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if ((r_state == ST_EM_WR || r_state == ST_EMPTY) && w_slot) begin
            r_ov <= 1'b1;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_EM_WR && w_slot) begin
            r_oa     <= w_p_q[15:8];
            r_ob     <= w_p_q[7:0];
            r_os     <= r_total;
            r_olast  <= (r_k + CW'(1) == r_cnt);
            r_oempty <= 1'b0;
        end else if (r_state == ST_EMPTY && w_slot) begin
            r_oa     <= '0;
            r_ob     <= '0;
            r_os     <= '0;
            r_olast  <= 1'b1;
            r_oempty <= 1'b1;
        end
    end

    assign o_out_valid   = r_ov;
    assign o_aligned_a   = r_oa;
    assign o_aligned_b   = r_ob;
    assign o_total_score = r_os;
    assign o_last        = r_olast;
    assign o_empty_res   = r_oempty;

`ifndef SYNTH
    a_path_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TB_US) |-> (r_cnt < CW'(PD)))
        else $error("traceback path overflow");

    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_empty_res) |-> o_last)
        else $error("empty result without last");

    a_wait_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WAIT) |=> (r_state == ST_WAIT || r_state == ST_TB_RD))
        else $error("fill wait left to wrong state");
`endif

endmodule
